// File: design/rhh_pkg.sv
`timescale 1ns / 1ps
package rhh_pkg;
  localparam int SlotCount = 1024;
  localparam int SlotBits = $clog2(SlotCount);
  localparam int KeyBits = 64;
  localparam int ValueBits = 32;
  localparam int CountBits = SlotBits + 1;
  localparam int EntryBits = 1 + KeyBits + ValueBits + SlotBits;

  localparam logic [KeyBits-1:0] HashC0 = 64'h9e3779b97f4a7c15;
  localparam logic [KeyBits-1:0] HashC1 = 64'hbf58476d1ce4e5b9;
  localparam logic [KeyBits-1:0] HashC2 = 64'h94d049bb133111eb;

  typedef enum logic [1:0] {
    FuncPut   = 2'd0,
    FuncGet   = 2'd1,
    FuncErase = 2'd2,
    FuncNone  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    StInserted = 3'd0,
    StUpdated  = 3'd1,
    StFound    = 3'd2,
    StNotFound = 3'd3,
    StErased   = 3'd4,
    StFull     = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]           func;
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value;
    logic [SlotBits-1:0]  home;
  } job_t;

  typedef struct packed {
    logic                 used;
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value;
    logic [SlotBits-1:0]  pdist;
  } entry_t;

  typedef enum logic [3:0] {
    SIdle,
    SProbeRd,
    SProbeChk,
    SInsRd,
    SInsChk,
    SDelRd,
    SDelChk,
    SReply,
    SClear
  } back_state_e;

  typedef enum logic [2:0] {
    HIdle,
    HMul1,
    HMul2,
    HPush
  } hash_state_e;
endpackage

// File: design/rhh_if.sv
`timescale 1ns / 1ps
interface rhh_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] key_word;
  logic [31:0] value_in;
  modport source (output valid, func, key_word, value_in, input ready);
  modport sink (input valid, func, key_word, value_in, output ready);
endinterface

interface rhh_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] value_out;
  logic [10:0] record_count;
  modport source (output valid, status, value_out, record_count, input ready);
  modport sink (input valid, status, value_out, record_count, output ready);
endinterface

// File: design/rhh_ram.sv
`timescale 1ns / 1ps
module rhh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: design/rhh_front.sv
`timescale 1ns / 1ps
module rhh_front import rhh_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  rhh_req_if.sink req,
  output logic    push_o,
  output job_t    job_o,
  input  logic    full_i
);
  hash_state_e st_q, st_d;
  job_t        job_q, job_d;
  logic [KeyBits-1:0] h_q, h_d, acc_q, acc_d, k1, k2, hf, opa, opb;
  logic [1:0]  ph_q, ph_d;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  assign k1 = h_q ^ (h_q >> 30);
  assign k2 = h_q ^ (h_q >> 27);
  assign hf = h_q ^ (h_q >> 31);

  // 64-bit product low half from three 32x32 partial products, one per cycle
  assign opa   = (st_q == HMul1) ? k1 : k2;
  assign opb   = (st_q == HMul1) ? HashC1 : HashC2;
  assign mul_a = (ph_q == 2'd2) ? opa[63:32] : opa[31:0];
  assign mul_b = (ph_q == 2'd1) ? opb[63:32] : opb[31:0];
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= HIdle;
      ph_q <= 2'd0;
    end else begin
      st_q <= st_d;
      ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    h_q   <= h_d;
    acc_q <= acc_d;
  end

  always_comb begin
    st_d      = st_q;
    ph_d      = ph_q;
    job_d     = job_q;
    h_d       = h_q;
    acc_d     = acc_q;
    req.ready = 1'b0;
    push_o    = 1'b0;
    job_o     = job_q;
    job_o.home = hf[SlotBits-1:0];
    case (st_q)
      HIdle: begin
        req.ready = 1'b1;
        if (req.valid) begin
          job_d.func  = req.func;
          job_d.key   = req.key_word;
          job_d.value = req.value_in;
          job_d.home  = '0;
          h_d  = req.key_word + HashC0;
          ph_d = 2'd0;
          st_d = HMul1;
        end
      end
      HMul1, HMul2: begin
        ph_d = ph_q + 2'd1;
        case (ph_q)
          2'd0: acc_d = mul_p;
          default: acc_d = acc_q + {mul_p[31:0], 32'd0};
        endcase
        if (ph_q == 2'd2) begin
          h_d  = acc_d;
          ph_d = 2'd0;
          st_d = (st_q == HMul1) ? HMul2 : HPush;
        end
      end
      HPush: begin
        if (!full_i) begin
          push_o = 1'b1;
          st_d   = HIdle;
        end
      end
      default: st_d = HIdle;
    endcase
  end
endmodule

// File: design/rhh_fifo.sv
`timescale 1ns / 1ps
module rhh_fifo import rhh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);
  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("bad count");
`endif
endmodule

// File: design/rhh_back.sv
`timescale 1ns / 1ps
module rhh_back import rhh_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  job_t                 job_i,
  output logic                 pop_o,
  input  logic [CountBits-1:0] max_records_i,
  output logic                 busy_o,
  rhh_rsp_if.source            rsp
);
  back_state_e st_q, st_d;
  job_t        job_q, job_d;
  logic [SlotBits-1:0]  pos_q, pos_d, hole_q, hole_d;
  logic [SlotBits-1:0]  clr_q, clr_d;
  logic [CountBits-1:0] d_q, d_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  entry_t cur_q, cur_d;
  logic [2:0]           status_q, status_d;
  logic [ValueBits-1:0] vout_q, vout_d;

  logic                we;
  logic [SlotBits-1:0] waddr, raddr;
  entry_t              wdata, rdata;
  logic                rused;
  logic [CountBits-1:0] limit;

  rhh_ram #(.Width(EntryBits), .Depth(SlotCount)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rused = rdata.used;
  assign limit = (max_records_i > CountBits'(SlotCount)) ? CountBits'(SlotCount)
                                                         : max_records_i;
  assign busy_o = (st_q != SIdle) || !empty_i;
  assign rsp.status       = status_q;
  assign rsp.value_out    = vout_q;
  assign rsp.record_count = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= SClear;
      cnt_q <= '0;
      clr_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    pos_q    <= pos_d;
    hole_q   <= hole_d;
    d_q      <= d_d;
    cur_q    <= cur_d;
    status_q <= status_d;
    vout_q   <= vout_d;
  end

  always_comb begin
    st_d      = st_q;
    job_d     = job_q;
    pos_d     = pos_q;
    hole_d    = hole_q;
    clr_d     = clr_q;
    d_d       = d_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    status_d  = status_q;
    vout_d    = vout_q;
    pop_o     = 1'b0;
    rsp.valid = 1'b0;
    we        = 1'b0;
    waddr     = pos_q;
    wdata     = rdata;
    raddr     = pos_q;
    case (st_q)
      SClear: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (&clr_q) st_d = SIdle;
      end
      SIdle: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          job_d  = job_i;
          pos_d  = job_i.home;
          d_d    = '0;
          vout_d = '0;
          if (job_i.func == FuncNone) begin
            status_d = StNotFound;
            st_d     = SReply;
          end else begin
            st_d = SProbeRd;
          end
        end
      end
      SProbeRd: st_d = SProbeChk;
      SProbeChk: begin
        if (!rused || CountBits'(rdata.pdist) < d_q || d_q == CountBits'(SlotCount)) begin
          if (job_q.func == FuncPut) begin
            if (cnt_q >= limit) begin
              status_d = StFull;
              st_d     = SReply;
            end else begin
              status_d  = StInserted;
              pos_d     = job_q.home;
              cur_d.used  = 1'b1;
              cur_d.key = job_q.key;
              cur_d.value = job_q.value;
              cur_d.pdist = '0;
              st_d = SInsRd;
            end
          end else begin
            status_d = StNotFound;
            st_d     = SReply;
          end
        end else if (rdata.key == job_q.key) begin
          case (job_q.func)
            FuncPut: begin
              we = 1'b1;
              wdata.value = job_q.value;
              status_d = StUpdated;
              st_d = SReply;
            end
            FuncGet: begin
              vout_d   = rdata.value;
              status_d = StFound;
              st_d     = SReply;
            end
            default: begin
              status_d = StErased;
              hole_d   = pos_q;
              pos_d    = pos_q + 1'b1;
              d_d      = '0;
              st_d     = SDelRd;
            end
          endcase
        end else begin
          pos_d = pos_q + 1'b1;
          d_d   = d_q + 1'b1;
          st_d  = SProbeRd;
        end
      end
      SInsRd: st_d = SInsChk;
      SInsChk: begin
        if (!rused) begin
          we       = 1'b1;
          wdata    = cur_q;
          wdata.used = 1'b1;
          cnt_d    = cnt_q + 1'b1;
          st_d     = SReply;
        end else begin
          if (rdata.pdist < cur_q.pdist) begin
            we    = 1'b1;
            wdata = cur_q;
            wdata.used = 1'b1;
            cur_d = rdata;
          end
          cur_d.pdist = ((rdata.pdist < cur_q.pdist) ? rdata.pdist : cur_q.pdist) + 1'b1;
          pos_d = pos_q + 1'b1;
          st_d  = SInsRd;
        end
      end
      SDelRd: st_d = SDelChk;
      SDelChk: begin
        // d_q counts shifts; the walk stops one slot short of a full lap
        if (!rused || rdata.pdist == '0 || d_q == CountBits'(SlotCount - 1)) begin
          we        = 1'b1;
          waddr     = hole_q;
          wdata     = '0;
          cnt_d     = cnt_q - 1'b1;
          st_d      = SReply;
        end else begin
          we          = 1'b1;
          waddr       = hole_q;
          wdata       = rdata;
          wdata.pdist = rdata.pdist - 1'b1;
          hole_d      = pos_q;
          pos_d       = pos_q + 1'b1;
          d_d         = d_q + 1'b1;
          st_d        = SDelRd;
        end
      end
      SReply: begin
        rsp.valid = 1'b1;
        if (rsp.ready) st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountBits'(SlotCount)) else $error("record count too large");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != SReply |=> $stable(cnt_q) || st_q == SReply) else $error("count moved late");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> st_q == SIdle) else $error("pop while busy");
`endif
endmodule

// File: design/robin_hood_hash_table.sv
`timescale 1ns / 1ps
// Flow: the hash stage takes a word, mixes the key and, when the queue has room, pushes
// the job into a 2-deep queue; the slot stage probes one slot at a time, walks slots on
// insert or erase, and holds the reply until it is taken. The hash stage takes a new word
// only once the last one has been pushed; the slot stage serves one word at a time.
// Reset: asynchronous; record count zero, max_records 798, then a clearing pass writes
// every slot before the first word is served.
module robin_hood_hash_table import rhh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rhh_req_if.sink     req,
  rhh_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [CountBits-1:0] max_q;
  logic push, pop, full, empty, busy;
  job_t fjob, bjob;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {{(32-CountBits){1'b0}}, max_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= CountBits'(798);
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      max_q <= pwdata[CountBits-1:0];
    end
  end

  rhh_front u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req),
    .push_o(push),
    .job_o (fjob),
    .full_i(full)
  );

  rhh_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (fjob),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (bjob)
  );

  rhh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .job_i        (bjob),
    .pop_o        (pop),
    .max_records_i(max_q),
    .busy_o       (busy),
    .rsp          (rsp)
  );

`ifndef NO_ASSERTIONS
  a_busy_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> busy) else $error("reply while idle");
`endif
endmodule

// File: tb/robin_hood_hash_table_checker.sv
`timescale 1ns / 1ps
module robin_hood_hash_table_checker import rhh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rhh_req_if          req,
  rhh_rsp_if          rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    status_e              status;
    logic [ValueBits-1:0] value;
    logic [CountBits-1:0] count;
  } answer_t;

  logic                 used_q  [SlotCount];
  logic [KeyBits-1:0]   key_q   [SlotCount];
  logic [ValueBits-1:0] value_q [SlotCount];
  int unsigned          dist_q  [SlotCount];
  int unsigned          records;
  int unsigned          limit;
  answer_t              answers[$];

  function automatic logic [SlotBits-1:0] home_slot(logic [63:0] k);
    k = k + 64'h9e3779b97f4a7c15;
    k = (k ^ (k >> 30)) * 64'hbf58476d1ce4e5b9;
    k = (k ^ (k >> 27)) * 64'h94d049bb133111eb;
    k = k ^ (k >> 31);
    return k[SlotBits-1:0];
  endfunction

  function automatic bit lookup(logic [KeyBits-1:0] k, output int where);
    int pos;
    pos = home_slot(k);
    where = 0;
    for (int d = 0; d < SlotCount; d++) begin
      if (!used_q[pos] || dist_q[pos] < d) return 0;
      if (key_q[pos] == k) begin
        where = pos;
        return 1;
      end
      pos = (pos + 1) % SlotCount;
    end
    return 0;
  endfunction

  function automatic void place(logic [KeyBits-1:0] k, logic [ValueBits-1:0] v);
    int pos;
    int unsigned cd, td;
    logic [KeyBits-1:0] tk;
    logic [ValueBits-1:0] tv;
    pos = home_slot(k);
    cd = 0;
    for (int s = 0; s < SlotCount; s++) begin
      if (!used_q[pos]) begin
        used_q[pos] = 1;
        key_q[pos] = k;
        value_q[pos] = v;
        dist_q[pos] = cd;
        records++;
        return;
      end
      if (dist_q[pos] < cd) begin
        tk = key_q[pos];
        tv = value_q[pos];
        td = dist_q[pos];
        key_q[pos] = k;
        value_q[pos] = v;
        dist_q[pos] = cd;
        k = tk;
        v = tv;
        cd = td;
      end
      pos = (pos + 1) % SlotCount;
      cd++;
    end
  endfunction

  function automatic void backshift(int pos);
    int hole, nxt;
    hole = pos;
    nxt = (hole + 1) % SlotCount;
    for (int s = 0; s + 1 < SlotCount; s++) begin
      if (!used_q[nxt] || dist_q[nxt] == 0) break;
      key_q[hole] = key_q[nxt];
      value_q[hole] = value_q[nxt];
      dist_q[hole] = dist_q[nxt] - 1;
      hole = nxt;
      nxt = (nxt + 1) % SlotCount;
    end
    used_q[hole] = 0;
    if (records > 0) records--;
  endfunction

  function automatic answer_t apply_word(func_e f, logic [KeyBits-1:0] k,
                                         logic [ValueBits-1:0] v);
    answer_t a;
    int where;
    a.status = StNotFound;
    a.value = '0;
    case (f)
      FuncPut: begin
        if (lookup(k, where)) begin
          value_q[where] = v;
          a.status = StUpdated;
        end else if (records >= limit || records >= SlotCount) begin
          a.status = StFull;
        end else begin
          place(k, v);
          a.status = StInserted;
        end
      end
      FuncGet: begin
        if (lookup(k, where)) begin
          a.value = value_q[where];
          a.status = StFound;
        end
      end
      FuncErase: begin
        if (lookup(k, where)) begin
          backshift(where);
          a.status = StErased;
        end
      end
      default: ;
    endcase
    a.count = records[CountBits-1:0];
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t e;
    if (!rst_ni) begin
      for (int i = 0; i < SlotCount; i++) used_q[i] = 0;
      records = 0;
      limit = 798;
      answers.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 2'd0) limit = pwdata[10:0];
      if (rsp.valid && rsp.ready) begin
        if (answers.size() == 0) begin
          $error("unexpected response word");
          fail_count_o++;
        end else begin
          e = answers.pop_front();
          if (rsp.status !== e.status) begin
            $error("status expected %0d got %0d", e.status, rsp.status);
            fail_count_o++;
          end
          if (rsp.value_out !== e.value) begin
            $error("value_out expected %h got %h", e.value, rsp.value_out);
            fail_count_o++;
          end
          if (rsp.record_count !== e.count) begin
            $error("record_count expected %0d got %0d", e.count, rsp.record_count);
            fail_count_o++;
          end
        end
      end
      if (req.valid && req.ready)
        answers.insert(answers.size(),
                       apply_word(func_e'(req.func), req.key_word, req.value_in));
      pending_o = answers.size();
    end
  end

endmodule

// File: tb/robin_hood_hash_table_test.sv
`timescale 1ns / 1ps
module robin_hood_hash_table_test import rhh_pkg::*;;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending, idle_cycles, burst_left;
  logic [63:0] key_pool[$];

  rhh_req_if req ();
  rhh_rsp_if rsp ();

  robin_hood_hash_table dut (
    .clk_i, .rst_ni, .req(req.sink), .rsp(rsp.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  robin_hood_hash_table_checker checker_i (
    .clk_i, .rst_ni, .req, .rsp, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial clk_i = 0;
  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // receiver stall pattern: always ready, ready at random, or ready one time in four
  int stall_mode, stall_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready <= 0;
      stall_mode <= 0;
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 64 == 63) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: rsp.ready <= 1;
        1: rsp.ready <= $urandom_range(0, 1);
        default: rsp.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 20000) begin
      $display("robin_hood_hash_table_test: FAIL");
      $finish;
    end
  end

  task automatic send_word(func_e f, logic [63:0] k, logic [31:0] v);
    int gap;
    if (burst_left == 0) begin
      req.valid <= 0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    req.valid <= 1;
    req.func <= f;
    req.key_word <= k;
    req.value_in <= v;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic drain();
    req.valid <= 0;
    burst_left = 0;
    do @(negedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [31:0] v);
    @(posedge clk_i);
    psel <= 1;
    pwrite <= 1;
    paddr <= 2'd0;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic random_phase(int words, int pool_size, int put_pct);
    int r;
    logic [63:0] k;
    func_e f;
    key_pool.delete();
    for (int i = 0; i < pool_size; i++) key_pool.insert(key_pool.size(), {$urandom, $urandom});
    key_pool.insert(key_pool.size(), '0);
    key_pool.insert(key_pool.size(), '1);
    for (int n = 0; n < words; n++) begin
      r = $urandom_range(0, 99);
      if (r < put_pct) f = FuncPut;
      else if (r < put_pct + (100 - put_pct) / 2) f = FuncGet;
      else if (r < 96) f = FuncErase;
      else f = FuncNone;
      if ($urandom_range(0, 9) == 0) k = {$urandom, $urandom};
      else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      send_word(f, k, $urandom);
    end
    drain();
  endtask

  initial begin
    rst_ni = 0;
    req.valid = 0;
    req.func = FuncPut;
    req.key_word = '0;
    req.value_in = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    burst_left = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;

    // directed: extremes, update, misses, erase, unused code
    send_word(FuncGet, '0, '0);
    send_word(FuncErase, '1, '0);
    send_word(FuncPut, '0, '1);
    send_word(FuncPut, '1, '0);
    send_word(FuncPut, '0, 32'h5a5a_a5a5);
    send_word(FuncGet, '0, '0);
    send_word(FuncGet, '1, '1);
    send_word(FuncPut, 64'h0123_4567_89ab_cdef, 32'hffff_ffff);
    send_word(FuncGet, 64'h0123_4567_89ab_cdef, '0);
    send_word(FuncNone, '1, '1);
    send_word(FuncErase, '0, '0);
    send_word(FuncGet, '0, '0);
    send_word(FuncGet, '1, '0);
    send_word(FuncErase, '1, '0);
    send_word(FuncErase, 64'h0123_4567_89ab_cdef, '0);
    drain();

    // record limit of one: refusals, update at the limit
    write_limit(32'd1);
    send_word(FuncPut, 64'h1, 32'h11);
    send_word(FuncPut, 64'h2, 32'h22);
    send_word(FuncPut, 64'h1, 32'h33);
    send_word(FuncGet, 64'h1, '0);
    drain();
    random_phase(60, 6, 50);

    write_limit(32'd40);
    random_phase(200, 60, 55);

    write_limit(32'd1024);
    random_phase(600, 700, 75);

    write_limit(32'd798);
    random_phase(170, 40, 40);

    if (fail_count == 0) $display("robin_hood_hash_table_test: PASS");
    else $display("robin_hood_hash_table_test: FAIL");
    $finish;
  end

endmodule
